### rtl/isp_pkg.sv
package isp_pkg;

  localparam int unsigned ImuDepthDefault    = 10;
  localparam int unsigned StrobeDepthDefault = 10;
  localparam int unsigned FrameBytes         = 64;
  localparam int unsigned ImuPerFrame        = 3;
  localparam int unsigned StrobePerFrame     = 2;
  localparam int unsigned ImuRecBytes        = 16;
  localparam int unsigned StrobeRecBytes     = 5;
  localparam int unsigned ImuSlot0           = 4;
  localparam int unsigned StrobeSlot0        = 52;
  localparam int unsigned SumLo              = 62;
  localparam int unsigned SumHi              = 63;
  localparam int unsigned InDataW            = 128;
  localparam logic [1:0]  ThresholdReset     = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT
  } ctrl_state_e;

  // byte source selected for the current frame position
  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_CNT_LO,
    SRC_CNT_HI,
    SRC_N_IMU,
    SRC_N_STB,
    SRC_IMU,
    SRC_STB,
    SRC_SUM
  } byte_src_e;

  typedef struct packed {
    logic       store_imu;
    logic       store_stb;
    logic       start;
    logic       emit;
    logic [5:0] pos;
    logic       done;
  } dp_cmd_t;

  typedef struct packed {
    logic send;
  } dp_status_t;

  // map a frame position to its byte source; ni, ns: record counts in the frame
  function automatic byte_src_e src_of(input logic [5:0] pos, input logic [1:0] ni,
                                       input logic [1:0] ns);
    byte_src_e s;
    s = SRC_ZERO;
    if (pos == 6'd0) s = SRC_CNT_LO;
    else if (pos == 6'd1) s = SRC_CNT_HI;
    else if (pos == 6'd2) s = SRC_N_IMU;
    else if (pos == 6'd3) s = SRC_N_STB;
    else if (pos < 6'(StrobeSlot0)) begin
      if (2'((pos - 6'(ImuSlot0)) >> 4) < ni) s = SRC_IMU;
    end else if (pos < 6'(SumLo)) begin
      if (pos < 6'(StrobeSlot0 + StrobeRecBytes)) begin
        if (ns != 2'd0) s = SRC_STB;
      end else if (pos < 6'(StrobeSlot0 + 2 * StrobeRecBytes)) begin
        if (ns == 2'd2) s = SRC_STB;
      end
    end else s = SRC_SUM;
    return s;
  endfunction

endpackage

### rtl/isp_ctrl.sv
module isp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_mode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_last_o,
  input  isp_pkg::dp_status_t status_i,
  output isp_pkg::dp_cmd_t    cmd_o
);

  isp_pkg::ctrl_state_e state_q, state_d;
  logic [5:0] pos_q, pos_d;
  logic       pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= isp_pkg::ST_IDLE;
      pos_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    pos_d         = pos_q;
    pend_d        = 1'b0;
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    out_last_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.pos     = pos_q;
    unique case (state_q)
      isp_pkg::ST_IDLE: begin
        // in the cycle after an imu store the fill count is settled
        if (pend_q) begin
          if (status_i.send) begin
            cmd_o.start = 1'b1;
            pos_d       = '0;
            state_d     = isp_pkg::ST_EMIT;
          end
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.store_imu = !in_mode_i;
            cmd_o.store_stb = in_mode_i;
            pend_d          = !in_mode_i;
          end
        end
      end
      isp_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        out_last_o  = (pos_q == 6'(isp_pkg::FrameBytes - 1));
        cmd_o.emit  = out_ready_i;
        if (out_ready_i) begin
          pos_d = pos_q + 6'd1;
          if (out_last_o) begin
            cmd_o.done = 1'b1;
            state_d    = isp_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = isp_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/isp_datapath.sv
module isp_datapath #(
  parameter int unsigned ImuDepth    = isp_pkg::ImuDepthDefault,
  parameter int unsigned StrobeDepth = isp_pkg::StrobeDepthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [isp_pkg::InDataW-1:0]       in_data_i,
  input  logic [1:0]                        threshold_i,
  input  isp_pkg::dp_cmd_t                  cmd_i,
  output isp_pkg::dp_status_t               status_o,
  output logic [7:0]                        byte_o
);

  localparam int unsigned IW = $clog2(ImuDepth);
  localparam int unsigned SW = $clog2(StrobeDepth);
  localparam int unsigned IFW = $clog2(ImuDepth + 1);
  localparam int unsigned SFW = $clog2(StrobeDepth + 1);

  logic [127:0] imu_mem [ImuDepth];
  logic [38:0]  stb_mem [StrobeDepth];

  logic [IW-1:0]  imu_head_q, imu_tail_q;
  logic [IFW-1:0] imu_fill_q;
  logic [SW-1:0]  stb_head_q, stb_tail_q;
  logic [SFW-1:0] stb_fill_q;
  logic [6:0]     stb_num_q;
  logic [15:0]    frame_cnt_q;
  logic [15:0]    sum_q;
  logic [1:0]     n_imu_q, n_stb_q;
  logic [1:0]     rec_q;
  logic [127:0]   imu_rec_q;
  logic [38:0]    stb_rec_q;
  logic [IW-1:0]  imu_rd;
  logic [SW-1:0]  stb_rd;
  logic [IW-1:0]  imu_head_nx;
  logic [SW-1:0]  stb_head_nx;
  logic [1:0]     n_imu_c, n_stb_c;
  isp_pkg::byte_src_e src, src_nx;
  logic [5:0]     pos_nx;
  logic [3:0]     off_imu;
  logic [5:0]     off_stb;
  logic [1:0]     rec_nx;

  function automatic logic [IW-1:0] imu_inc(input logic [IW-1:0] v);
    return (v == IW'(ImuDepth - 1)) ? '0 : v + IW'(1);
  endfunction
  function automatic logic [SW-1:0] stb_inc(input logic [SW-1:0] v);
    return (v == SW'(StrobeDepth - 1)) ? '0 : v + SW'(1);
  endfunction

  assign imu_head_nx = imu_inc(imu_head_q);
  assign stb_head_nx = stb_inc(stb_head_q);
  assign n_imu_c = (imu_fill_q > IFW'(3)) ? 2'd3 : imu_fill_q[1:0];
  assign n_stb_c = (stb_fill_q > SFW'(2)) ? 2'd2 : stb_fill_q[1:0];
  assign status_o.send = ({{(IFW > 2 ? IFW - 2 : 0){1'b0}}, threshold_i} <= imu_fill_q);

  assign src    = isp_pkg::src_of(cmd_i.pos, n_imu_q, n_stb_q);
  assign pos_nx = cmd_i.pos + 6'd1;
  assign src_nx = isp_pkg::src_of(pos_nx, n_imu_q, n_stb_q);
  // record index whose bytes follow at the next position
  assign rec_nx = (pos_nx < 6'(isp_pkg::ImuSlot0)) ? 2'd0
                : (pos_nx < 6'(isp_pkg::StrobeSlot0))
                  ? 2'((pos_nx - 6'(isp_pkg::ImuSlot0)) >> 4)
                : ((pos_nx < 6'd57) ? 2'd0 : 2'd1);

  // tail pointer of the record to prefetch; steps past the last record at the area end
  always_comb begin
    imu_rd = imu_tail_q;
    stb_rd = stb_tail_q;
    if (cmd_i.emit) begin
      if ((src_nx == isp_pkg::SRC_IMU && rec_nx != rec_q) ||
          (cmd_i.pos == 6'd51 && n_imu_q != 2'd0)) begin
        imu_rd = imu_inc(imu_tail_q);
      end
      if ((src_nx == isp_pkg::SRC_STB && pos_nx == 6'd57) ||
          (cmd_i.pos == 6'd61 && n_stb_q != 2'd0)) begin
        stb_rd = stb_inc(stb_tail_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_imu) imu_mem[imu_head_q] <= in_data_i[127:0];
    if (cmd_i.store_stb) stb_mem[stb_head_q] <= {stb_num_q, in_data_i[31:0]};
    imu_rec_q <= imu_mem[imu_rd];
    stb_rec_q <= stb_mem[stb_rd];
  end

  always_comb begin
    off_imu = 4'(cmd_i.pos - 6'(isp_pkg::ImuSlot0));
    off_stb = (cmd_i.pos < 6'd57) ? cmd_i.pos - 6'd52 : cmd_i.pos - 6'd57;
    unique case (src)
      isp_pkg::SRC_ZERO:   byte_o = 8'h00;
      isp_pkg::SRC_CNT_LO: byte_o = frame_cnt_q[7:0];
      isp_pkg::SRC_CNT_HI: byte_o = frame_cnt_q[15:8];
      isp_pkg::SRC_N_IMU:  byte_o = {6'd0, n_imu_q};
      isp_pkg::SRC_N_STB:  byte_o = {6'd0, n_stb_q};
      isp_pkg::SRC_IMU:    byte_o = imu_rec_q[{off_imu, 3'd0} +: 8];
      isp_pkg::SRC_STB:    byte_o = (off_stb == 6'd4) ? {1'b0, stb_rec_q[38:32]}
                                    : stb_rec_q[{off_stb[1:0], 3'd0} +: 8];
      isp_pkg::SRC_SUM:    byte_o = (cmd_i.pos == 6'(isp_pkg::SumLo)) ? sum_q[7:0]
                                    : sum_q[15:8];
      default:             byte_o = 8'h00;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imu_head_q  <= '0;
      imu_tail_q  <= '0;
      imu_fill_q  <= '0;
      stb_head_q  <= '0;
      stb_tail_q  <= '0;
      stb_fill_q  <= '0;
      stb_num_q   <= '0;
      frame_cnt_q <= '0;
      sum_q       <= '0;
      n_imu_q     <= '0;
      n_stb_q     <= '0;
      rec_q       <= '0;
    end else begin
      if (cmd_i.store_imu) begin
        imu_head_q <= imu_head_nx;
        if (imu_head_nx == imu_tail_q) imu_tail_q <= imu_inc(imu_tail_q);
        if (imu_fill_q != IFW'(ImuDepth)) imu_fill_q <= imu_fill_q + IFW'(1);
      end
      if (cmd_i.store_stb) begin
        stb_head_q <= stb_head_nx;
        stb_num_q  <= stb_num_q + 7'd1;
        if (stb_head_nx == stb_tail_q) stb_tail_q <= stb_inc(stb_tail_q);
        if (stb_fill_q != SFW'(StrobeDepth)) stb_fill_q <= stb_fill_q + SFW'(1);
      end
      if (cmd_i.start) begin
        n_imu_q    <= n_imu_c;
        n_stb_q    <= n_stb_c;
        imu_fill_q <= imu_fill_q - IFW'(n_imu_c);
        stb_fill_q <= stb_fill_q - SFW'(n_stb_c);
        sum_q      <= '0;
        rec_q      <= '0;
      end
      if (cmd_i.emit) begin
        if (cmd_i.pos < 6'(isp_pkg::SumLo)) sum_q <= sum_q + 16'(byte_o);
        imu_tail_q <= imu_rd;
        stb_tail_q <= stb_rd;
        rec_q      <= rec_nx;
      end
      if (cmd_i.done) frame_cnt_q <= frame_cnt_q + 16'd1;
    end
  end

endmodule

### rtl/imu_strobe_stamp_packetizer_core.sv
// tvalid of a frame's first byte rises after the imu sample transfer sets pend, the fill
//   count meets the threshold and the controller enters ST_EMIT
// input: one strobe event per cycle while idle; an imu sample holds the input until
//   the fill count settles and a frame it sends is out, one byte per cycle but for stalls
// reset: pointers, counts, strobe number and frame counter clear, threshold is 3;
//   ring contents stay undefined until written
module imu_strobe_stamp_packetizer_core #(
  parameter int unsigned ImuDepth    = isp_pkg::ImuDepthDefault,
  parameter int unsigned StrobeDepth = isp_pkg::StrobeDepthDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // time_us, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  input  logic [127:0] s_axis_tdata,
  // mode
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // frame_byte
  output logic [7:0]   m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_data_i
);

  logic [1:0] threshold_q;
  isp_pkg::dp_cmd_t    cmd;
  isp_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) threshold_q <= isp_pkg::ThresholdReset;
    else if (cfg_valid_i) threshold_q <= cfg_data_i;
  end

  isp_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_last_o  (m_axis_tlast),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  isp_datapath #(
    .ImuDepth    (ImuDepth),
    .StrobeDepth (StrobeDepth)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .in_data_i   (s_axis_tdata),
    .threshold_i (threshold_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .byte_o      (m_axis_tdata)
  );

endmodule
